// ===== src/text_console_writer_core_macros.svh =====
// Assertion macros shared by the text console writer modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// Types and constants shared by the text console writer modules.
package tcw_pkg;

   localparam int FUNC_W   = 2;
   localparam int CODE_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int ADDR_W   = 11;
   localparam int CELL_W   = 16;
   localparam int COLOUR_W = 8;

   localparam logic [CODE_W-1:0]   CHAR_TAB       = 8'h09;
   localparam logic [CODE_W-1:0]   CHAR_CR        = 8'h0D;
   localparam logic [CODE_W-1:0]   CHAR_PRINT_MIN = 8'd32;
   localparam logic [CODE_W-1:0]   CHAR_SPACE     = 8'd32;
   localparam logic [COLOUR_W-1:0] COLOUR_RESET   = 8'd15;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_GOTO  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_READ  = 2'd3
   } tcw_func_type;

   // What a memory sweep writes
   typedef enum logic [1:0] {
      SWEEP_ZERO   = 2'd0,
      SWEEP_BLANK  = 2'd1,
      SWEEP_SCROLL = 2'd2
   } tcw_sweep_type;

   typedef enum logic [1:0] {
      WR_CHAR  = 2'd0,
      WR_COPY  = 2'd1,
      WR_BLANK = 2'd2,
      WR_ZERO  = 2'd3
   } tcw_wr_kind_type;

   typedef struct packed {
      logic          capture;
      logic          exec;
      logic          sweep;
      tcw_sweep_type sweep_mode;
   } tcw_cmd_type;

   typedef struct packed {
      tcw_func_type func;
      logic         need_scroll;
      logic         sweep_last;
   } tcw_status_type;

endpackage

// ===== src/text_console_writer_core.sv =====
// Text console writer top level: configuration register and module wiring.
// Put character, goto and read cell pass from idle through the execute and result states:
// busy is high in both and the result strobe rsp_valid marks the second. Clear screen,
// and a put character that scrolls, walk the whole screen memory one cell a cycle
// through its single write port and then a write flush state before the result, with busy
// high throughout. After reset the memory is zeroed by the same walk, with busy high
// until it ends; csr writes are taken at any time. The result is on the rsp_ ports in
// the rsp_valid cycle and cannot be stalled.
module text_console_writer_core import tcw_pkg::*; #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic [COL_W-1:0]    req_goto_x,
   input  logic [ROW_W-1:0]    req_goto_y,
   input  logic [ADDR_W-1:0]   req_cell_address,
   output logic                rsp_valid,
   output logic [CELL_W-1:0]   rsp_cell_value,
   output logic [COL_W-1:0]    rsp_cursor_x,
   output logic [ROW_W-1:0]    rsp_cursor_y,
   output logic [ADDR_W-1:0]   rsp_cursor_position,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COLOUR_W-1:0] csr_data
);

   logic [COLOUR_W-1:0] colour_ff, colour_in;
   tcw_cmd_type         cmd;
   tcw_status_type      status;

   assign csr_ready = 1'b1;
   assign colour_in = (csr_valid && csr_ready) ? csr_data : colour_ff;

   always_ff @(posedge clock) begin
      if (reset) colour_ff <= COLOUR_RESET;
      else colour_ff <= colour_in;
   end

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STOP      (TAB_STOP)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .colour              (colour_ff),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_goto_x          (req_goto_x),
      .req_goto_y          (req_goto_y),
      .req_cell_address    (req_cell_address),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_x        (rsp_cursor_x),
      .rsp_cursor_y        (rsp_cursor_y),
      .rsp_cursor_position (rsp_cursor_position)
   );

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller state machine for the text console writer.
`include "text_console_writer_core_macros.svh"

module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_SWEEP = 6'b001000,
      ST_FLUSH = 6'b010000,
      ST_RESP  = 6'b100000
   } tcw_state_type;

   tcw_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.func == FUNC_CLEAR || status.need_scroll) state_in = ST_SWEEP;
            else state_in = ST_RESP;
         end
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && start;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.sweep   = (state_ff == ST_INIT) || (state_ff == ST_SWEEP);
      if (state_ff == ST_INIT) cmd.sweep_mode = SWEEP_ZERO;
      else if (status.func == FUNC_CLEAR) cmd.sweep_mode = SWEEP_BLANK;
      else cmd.sweep_mode = SWEEP_SCROLL;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   `TCW_ASSERT_NEXT(a_resp_returns_idle, clock, reset, state_ff == ST_RESP,
      state_ff == ST_IDLE, "result strobe not followed by idle")
   `TCW_ASSERT_NEXT(a_accept_goes_exec, clock, reset, start && (state_ff == ST_IDLE),
      state_ff == ST_EXEC, "accepted transaction did not execute")
   `TCW_ASSERT_NEXT(a_sweep_end_flush, clock, reset,
      (state_ff == ST_SWEEP) && status.sweep_last, state_ff == ST_FLUSH,
      "sweep end not followed by write flush")

endmodule

// ===== src/tcw_datapath.sv =====
// Datapath: screen memory, cursor registers, sweep counter and result muxing.
`include "text_console_writer_core_macros.svh"

module tcw_datapath import tcw_pkg::*; #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_cmd_type         cmd,
   output tcw_status_type      status,
   input  logic [COLOUR_W-1:0] colour,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic [COL_W-1:0]    req_goto_x,
   input  logic [ROW_W-1:0]    req_goto_y,
   input  logic [ADDR_W-1:0]   req_cell_address,
   output logic [CELL_W-1:0]   rsp_cell_value,
   output logic [COL_W-1:0]    rsp_cursor_x,
   output logic [ROW_W-1:0]    rsp_cursor_y,
   output logic [ADDR_W-1:0]   rsp_cursor_position
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_COUNT = CELL_COUNT - SCREEN_WIDTH;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int CMP_W      = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;
   localparam int PROD_W     = ROW_W + COL_W;
   localparam int TAB_ROWS   = 1 << COL_W;

   logic [CELL_W-1:0] mem [0:CELL_COUNT-1];

   tcw_func_type      func_ff;
   logic [CODE_W-1:0] char_ff;
   logic [COL_W-1:0]  gx_ff;
   logic [ROW_W-1:0]  gy_ff;
   logic              read_ok_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;

   logic              wr_en_ff, wr_en_in;
   tcw_wr_kind_type   wr_kind_ff, wr_kind_in;
   logic [IDX_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] wr_data;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [CELL_W-1:0] rd_data_ff;

   logic [CMP_W-1:0]  addr_ext;
   logic [COL_W:0]    tab_lut [0:TAB_ROWS-1];
   logic [COL_W:0]    col_t;
   logic              wrap;
   logic [ROW_W-1:0]  row_t;
   logic              scroll;
   logic [COL_W-1:0]  col_put;
   logic [ROW_W-1:0]  row_put;
   logic [PROD_W-1:0] pos_full;
   logic              printable;
   logic              sweep_last;
   logic              in_copy;

   // next tab stop for every column, settled at elaboration
   for (genvar c = 0; c < TAB_ROWS; c++) begin : g_tab
      localparam int NEXT_STOP = ((c + TAB_STOP) / TAB_STOP) * TAB_STOP;
      assign tab_lut[c] = (COL_W+1)'(NEXT_STOP);
   end

   assign addr_ext = CMP_W'(req_cell_address);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= tcw_func_type'(req_func);
         char_ff    <= req_char_code;
         gx_ff      <= req_goto_x;
         gy_ff      <= req_goto_y;
         read_ok_ff <= (addr_ext < CMP_W'(CELL_COUNT));
         rd_idx_ff  <= addr_ext[IDX_W-1:0];
      end
   end

   // cursor after a put character
   assign printable = (char_ff >= CHAR_PRINT_MIN);
   assign pos_full  = PROD_W'(row_ff) * PROD_W'(SCREEN_WIDTH) + PROD_W'(col_ff);

   always_comb begin
      if (char_ff == CHAR_TAB) col_t = tab_lut[col_ff];
      else if (char_ff == CHAR_CR) col_t = '0;
      else if (printable) col_t = {1'b0, col_ff} + (COL_W+1)'(1);
      else col_t = {1'b0, col_ff};
   end

   assign wrap    = (col_t >= (COL_W+1)'(SCREEN_WIDTH));
   assign row_t   = row_ff + ROW_W'(wrap);
   assign scroll  = (row_t >= ROW_W'(SCREEN_HEIGHT));
   assign col_put = wrap ? '0 : col_t[COL_W-1:0];
   assign row_put = scroll ? ROW_W'(SCREEN_HEIGHT - 1) : row_t;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.exec) begin
         unique case (func_ff)
            FUNC_PUT: begin
               col_in = col_put;
               row_in = row_put;
            end
            FUNC_GOTO: begin
               if (gx_ff < COL_W'(SCREEN_WIDTH)) col_in = gx_ff;
               if (gy_ff < ROW_W'(SCREEN_HEIGHT)) row_in = gy_ff;
            end
            FUNC_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            FUNC_READ: begin
               col_in = col_ff;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   // sweep over the whole memory: copy up a row, blank or zero
   assign sweep_last = (sweep_ff == IDX_W'(CELL_COUNT - 1));
   assign in_copy    = (sweep_ff < IDX_W'(COPY_COUNT));

   always_comb begin
      if (cmd.exec) sweep_in = '0;
      else if (cmd.sweep) sweep_in = sweep_ff + IDX_W'(1);
      else sweep_in = sweep_ff;
   end

   // writes are queued in a register stage so a copy can use the registered read data
   always_comb begin
      wr_en_in   = 1'b0;
      wr_kind_in = WR_CHAR;
      wr_addr_in = sweep_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_idx_ff;
      if (cmd.sweep) begin
         wr_en_in = 1'b1;
         unique case (cmd.sweep_mode)
            SWEEP_ZERO:  wr_kind_in = WR_ZERO;
            SWEEP_BLANK: wr_kind_in = WR_BLANK;
            SWEEP_SCROLL: begin
               if (in_copy) begin
                  wr_kind_in = WR_COPY;
                  rd_en      = 1'b1;
                  rd_addr    = sweep_ff + IDX_W'(SCREEN_WIDTH);
               end else begin
                  wr_kind_in = WR_BLANK;
               end
            end
            default: wr_kind_in = WR_ZERO;
         endcase
      end else if (cmd.exec) begin
         if (func_ff == FUNC_PUT && printable) begin
            wr_en_in   = 1'b1;
            wr_kind_in = WR_CHAR;
            wr_addr_in = pos_full[IDX_W-1:0];
         end
         if (func_ff == FUNC_READ && read_ok_ff) rd_en = 1'b1;
      end
   end

   always_comb begin
      unique case (wr_kind_ff)
         WR_CHAR:  wr_data = {colour, char_ff};
         WR_COPY:  wr_data = rd_data_ff;
         WR_BLANK: wr_data = {colour, CHAR_SPACE};
         WR_ZERO:  wr_data = '0;
         default:  wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) mem[wr_addr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         sweep_ff <= '0;
         wr_en_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         sweep_ff <= sweep_in;
         wr_en_ff <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_kind_ff <= wr_kind_in;
      wr_addr_ff <= wr_addr_in;
   end

   assign status.func        = func_ff;
   assign status.need_scroll = (func_ff == FUNC_PUT) && scroll;
   assign status.sweep_last  = sweep_last;

   assign rsp_cell_value      = (func_ff == FUNC_READ && read_ok_ff) ? rd_data_ff : '0;
   assign rsp_cursor_x        = col_ff;
   assign rsp_cursor_y        = row_ff;
   assign rsp_cursor_position = pos_full[ADDR_W-1:0];

   `TCW_ASSERT_NOW(a_cursor_on_screen, clock, reset, 1'b1,
      (col_ff < COL_W'(SCREEN_WIDTH)) && (row_ff < ROW_W'(SCREEN_HEIGHT)),
      "cursor left the screen")
   `TCW_ASSERT_NOW(a_write_in_range, clock, reset, wr_en_ff,
      wr_addr_ff <= IDX_W'(CELL_COUNT - 1), "screen write beyond last cell")
   `TCW_ASSERT_NOW(a_read_in_range, clock, reset, rd_en,
      rd_addr <= IDX_W'(CELL_COUNT - 1), "screen read beyond last cell")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for text_console_writer_core: cursor, screen memory and colour register.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int TAB_STOP      = 8;
   localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int IDLE_LIMIT    = 20000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 225;
   localparam int SETTLE_CYCLES = CELL_COUNT + 100;

   typedef struct {
      tcw_func_type      func;
      logic [CODE_W-1:0] char_code;
      logic [COL_W-1:0]  goto_x;
      logic [ROW_W-1:0]  goto_y;
      logic [ADDR_W-1:0] cell_address;
   } console_cmd_type;

   typedef struct {
      logic [CELL_W-1:0] cell_value;
      logic [COL_W-1:0]  cursor_x;
      logic [ROW_W-1:0]  cursor_y;
      logic [ADDR_W-1:0] cursor_position;
   } cursor_report_type;

   class console_scoreboard_type;
      logic [CELL_W-1:0]   cells [CELL_COUNT];
      int unsigned         column;
      int unsigned         row;
      logic [COLOUR_W-1:0] colour;
      cursor_report_type   due_reports [$];
      int unsigned         failures;
      int unsigned         checked;
      int unsigned         scrolls;
      int unsigned         colour_writes;
      int unsigned         func_seen [4];

      function new();
         foreach (cells[i]) cells[i] = '0;
         foreach (func_seen[i]) func_seen[i] = 0;
         column        = 0;
         row           = 0;
         colour        = COLOUR_RESET;
         failures      = 0;
         checked       = 0;
         scrolls       = 0;
         colour_writes = 0;
      endfunction

      function logic [CELL_W-1:0] blank_cell();
         return {colour, CHAR_SPACE};
      endfunction

      function void set_colour(logic [COLOUR_W-1:0] value);
         colour = value;
         colour_writes++;
      endfunction

      function void scroll_screen();
         for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++) cells[i] = cells[i + SCREEN_WIDTH];
         for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++) cells[i] = blank_cell();
         scrolls++;
      endfunction

      function void put_char(logic [CODE_W-1:0] code);
         if (code == CHAR_TAB) begin
            column = ((column + TAB_STOP) / TAB_STOP) * TAB_STOP;
         end else if (code == CHAR_CR) begin
            column = 0;
         end else if (code >= CHAR_PRINT_MIN) begin
            cells[row * SCREEN_WIDTH + column] = {colour, code};
            column++;
         end
         // other control codes only reach the wrap and scroll checks
         if (column >= SCREEN_WIDTH) begin
            column = 0;
            row++;
         end
         if (row >= SCREEN_HEIGHT) begin
            scroll_screen();
            row = SCREEN_HEIGHT - 1;
         end
      endfunction

      function cursor_report_type apply_command(console_cmd_type cmd);
         cursor_report_type rep;
         rep.cell_value = '0;
         unique case (cmd.func)
            FUNC_PUT: put_char(cmd.char_code);
            FUNC_GOTO: begin
               if (cmd.goto_x < SCREEN_WIDTH) column = cmd.goto_x;
               if (cmd.goto_y < SCREEN_HEIGHT) row = cmd.goto_y;
            end
            FUNC_CLEAR: begin
               foreach (cells[i]) cells[i] = blank_cell();
               column = 0;
               row    = 0;
            end
            FUNC_READ: begin
               if (cmd.cell_address < CELL_COUNT) rep.cell_value = cells[cmd.cell_address];
            end
         endcase
         rep.cursor_x        = COL_W'(column);
         rep.cursor_y        = ROW_W'(row);
         rep.cursor_position = ADDR_W'(row * SCREEN_WIDTH + column);
         return rep;
      endfunction

      function void note_command(console_cmd_type cmd);
         func_seen[cmd.func]++;
         due_reports.push_back(apply_command(cmd));
      endfunction

      function void compare_field(string field, logic [CELL_W-1:0] want,
                                  logic [CELL_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_report(cursor_report_type got);
         cursor_report_type want;
         if (due_reports.size() == 0) begin
            $error("result with no command outstanding: cursor %0d,%0d",
                   got.cursor_x, got.cursor_y);
            failures++;
            return;
         end
         want = due_reports.pop_front();
         checked++;
         compare_field("cell_value", want.cell_value, got.cell_value);
         compare_field("cursor_x", CELL_W'(want.cursor_x), CELL_W'(got.cursor_x));
         compare_field("cursor_y", CELL_W'(want.cursor_y), CELL_W'(got.cursor_y));
         compare_field("cursor_position", CELL_W'(want.cursor_position),
                       CELL_W'(got.cursor_position));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [CODE_W-1:0]   req_char_code = '0;
   logic [COL_W-1:0]    req_goto_x = '0;
   logic [ROW_W-1:0]    req_goto_y = '0;
   logic [ADDR_W-1:0]   req_cell_address = '0;
   logic                rsp_valid;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic [COL_W-1:0]    rsp_cursor_x;
   logic [ROW_W-1:0]    rsp_cursor_y;
   logic [ADDR_W-1:0]   rsp_cursor_position;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COLOUR_W-1:0] csr_data = '0;

   console_scoreboard_type board;
   int unsigned            text_left = 0;
   int unsigned            quiet_cycles = 0;

   text_console_writer_core #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STOP      (TAB_STOP)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_goto_x          (req_goto_x),
      .req_goto_y          (req_goto_y),
      .req_cell_address    (req_cell_address),
      .rsp_valid           (rsp_valid),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_x        (rsp_cursor_x),
      .rsp_cursor_y        (rsp_cursor_y),
      .rsp_cursor_position (rsp_cursor_position),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result checked before the command of the same edge is noted
   always @(posedge clock) begin
      cursor_report_type got;
      console_cmd_type   cmd;
      if (!reset) begin
         if (rsp_valid) begin
            got.cell_value      = rsp_cell_value;
            got.cursor_x        = rsp_cursor_x;
            got.cursor_y        = rsp_cursor_y;
            got.cursor_position = rsp_cursor_position;
            board.check_report(got);
         end
         if (start && !busy) begin
            cmd.func         = tcw_func_type'(req_func);
            cmd.char_code    = req_char_code;
            cmd.goto_x       = req_goto_x;
            cmd.goto_y       = req_goto_y;
            cmd.cell_address = req_cell_address;
            board.note_command(cmd);
         end
         if (csr_valid && csr_ready) board.set_colour(csr_data);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic console_cmd_type make_cmd(tcw_func_type func, int unsigned code,
                                                int unsigned gx, int unsigned gy,
                                                int unsigned addr);
      console_cmd_type cmd;
      cmd.func         = func;
      cmd.char_code    = CODE_W'(code);
      cmd.goto_x       = COL_W'(gx);
      cmd.goto_y       = ROW_W'(gy);
      cmd.cell_address = ADDR_W'(addr);
      return cmd;
   endfunction

   function automatic console_cmd_type random_command();
      console_cmd_type cmd;
      int unsigned     pick;
      int              near_addr;
      cmd.func         = FUNC_PUT;
      cmd.char_code    = CODE_W'($urandom);
      cmd.goto_x       = COL_W'($urandom);
      cmd.goto_y       = ROW_W'($urandom);
      cmd.cell_address = ADDR_W'($urandom);
      if (text_left != 0) begin
         text_left--;
         cmd.char_code = CODE_W'($urandom_range(32, 255));
         return cmd;
      end
      pick = $urandom_range(0, 999);
      if (pick < 15) begin
         // start a line of text, at least half of them on the bottom row so they can scroll
         text_left   = $urandom_range(20, 130);
         cmd.func    = FUNC_GOTO;
         cmd.goto_x  = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
         cmd.goto_y  = ($urandom_range(0, 1) != 0) ? ROW_W'(SCREEN_HEIGHT - 1) :
                                                     ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
      end else if (pick < 20) begin
         cmd.func = FUNC_CLEAR;
      end else if (pick < 140) begin
         cmd.func = FUNC_GOTO;
         if ($urandom_range(0, 3) == 0)
            cmd.goto_y = ROW_W'($urandom_range(SCREEN_HEIGHT - 3, SCREEN_HEIGHT - 1));
      end else if (pick < 460) begin
         cmd.func = FUNC_READ;
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            near_addr = int'(board.row * SCREEN_WIDTH + board.column)
                        - int'($urandom_range(0, 2 * SCREEN_WIDTH));
            cmd.cell_address = (near_addr < 0) ? '0 : ADDR_W'(near_addr);
         end else if (pick < 6) begin
            cmd.cell_address = ADDR_W'($urandom_range(CELL_COUNT - SCREEN_WIDTH, 2047));
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 12)      cmd.char_code = CHAR_TAB;
         else if (pick < 16) cmd.char_code = CHAR_CR;
         else if (pick < 26) cmd.char_code = CODE_W'($urandom_range(0, 31));
         else                cmd.char_code = CODE_W'($urandom_range(32, 255));
      end
      return cmd;
   endfunction

   // Called at a falling edge; returns at the edge that takes the transaction
   task automatic drive_command(console_cmd_type cmd);
      start            <= 1'b1;
      req_func         <= cmd.func;
      req_char_code    <= cmd.char_code;
      req_goto_x       <= cmd.goto_x;
      req_goto_y       <= cmd.goto_y;
      req_cell_address <= cmd.cell_address;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_command(console_cmd_type cmd);
      @(negedge clock);
      drive_command(cmd);
   endtask

   task automatic hold_off(int unsigned cycles);
      @(negedge clock);
      start            <= 1'b0;
      req_func         <= FUNC_W'($urandom);
      req_char_code    <= CODE_W'($urandom);
      req_goto_x       <= COL_W'($urandom);
      req_goto_y       <= ROW_W'($urandom);
      req_cell_address <= ADDR_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Sweeps (clear, scroll) keep busy high until their result, so wait on both
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (board.due_reports.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_colour(logic [COLOUR_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_command(make_cmd(FUNC_READ, 0, 0, 0, 0));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, CELL_COUNT - 1));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, CELL_COUNT));     // just past the screen
      send_command(make_cmd(FUNC_READ, 0, 0, 0, 2047));
      send_command(make_cmd(FUNC_PUT, 8'h41, 0, 0, 0));
      send_command(make_cmd(FUNC_PUT, 8'hFF, 0, 0, 0));
      send_command(make_cmd(FUNC_PUT, CHAR_SPACE, 0, 0, 0));
      send_command(make_cmd(FUNC_PUT, 8'h1F, 0, 0, 0));           // ignored control codes
      send_command(make_cmd(FUNC_PUT, 8'h00, 0, 0, 0));
      send_command(make_cmd(FUNC_PUT, CHAR_TAB, 0, 0, 0));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, 1));
      send_command(make_cmd(FUNC_PUT, CHAR_CR, 0, 0, 0));
      send_command(make_cmd(FUNC_GOTO, 0, 127, 31, 0));           // both out of range
      send_command(make_cmd(FUNC_GOTO, 0, SCREEN_WIDTH, 3, 0));
      send_command(make_cmd(FUNC_GOTO, 0, 9, SCREEN_HEIGHT, 0));
      send_command(make_cmd(FUNC_GOTO, 0, SCREEN_WIDTH - 2, 3, 0));
      send_command(make_cmd(FUNC_PUT, CHAR_TAB, 0, 0, 0));        // tab wraps to next row
      send_command(make_cmd(FUNC_GOTO, 0, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0));
      send_command(make_cmd(FUNC_PUT, 8'h5A, 0, 0, 0));           // last cell, then scroll
      send_command(make_cmd(FUNC_READ, 0, 0, 0, CELL_COUNT - SCREEN_WIDTH - 1));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, CELL_COUNT - 1));
      write_colour(8'h00);
      send_command(make_cmd(FUNC_GOTO, 0, SCREEN_WIDTH - 5, SCREEN_HEIGHT - 1, 0));
      send_command(make_cmd(FUNC_PUT, CHAR_TAB, 0, 0, 0));        // tab off the bottom row
      send_command(make_cmd(FUNC_CLEAR, 0, 0, 0, 0));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, CELL_COUNT - 1));
      write_colour(8'hFF);
      send_command(make_cmd(FUNC_PUT, 8'h7E, 0, 0, 0));
      send_command(make_cmd(FUNC_READ, 0, 0, 0, 0));
   endtask

   task automatic run_random_phase(int unsigned items);
      int unsigned burst;
      burst = $urandom_range(1, 30);
      for (int unsigned n = 0; n < items; n++) begin
         @(negedge clock);
         drive_command(random_command());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            case ($urandom_range(0, 9))
               0, 1, 2: ;
               3:       drain();
               9:       hold_off($urandom_range(20, 60));
               default: hold_off($urandom_range(1, 8));
            endcase
         end
      end
   endtask

   initial begin
      logic [COLOUR_W-1:0] phase_colour;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       phase_colour = 8'h00;
            1:       phase_colour = 8'hFF;
            2:       phase_colour = COLOUR_RESET;
            default: phase_colour = COLOUR_W'($urandom);
         endcase
         write_colour(phase_colour);
         run_random_phase(PHASE_ITEMS);
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d put, %0d goto, %0d clear, %0d read commands; %0d results checked",
               board.func_seen[FUNC_PUT], board.func_seen[FUNC_GOTO],
               board.func_seen[FUNC_CLEAR], board.func_seen[FUNC_READ], board.checked);
      $display("screen scrolled %0d times across %0d colour settings",
               board.scrolls, board.colour_writes);
      if (board.failures == 0 && board.due_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
